// ===== rtl/lgts_pkg.sv =====
// ----------------------------------------------------------------------------
// lgts_pkg
// Shared types, register map and constants of the LDA Gibbs topic sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lgts_pkg;

  // default sizing of the count tables
  localparam int MaxTopicsDefault     = 64;
  localparam int MaxVocabularyDefault = 4096;
  localparam int WordCountBitsDefault = 24;

  // weights and cumulative sums are Q16.16 held in 48 bits
  localparam int WeightBits = 48;
  localparam int DivBits    = 49;   // width of the Q16.16 divisor
  localparam int VbBits     = 45;   // vocabulary times beta

  localparam logic [WeightBits-1:0] WeightMax = '1;

  // configuration reset values
  localparam logic [31:0] AlphaReset = 32'd65536;
  localparam logic [31:0] BetaReset  = 32'd6554;
  localparam logic [6:0]  TopicsReset = 7'd64;
  localparam logic [12:0] VocabReset  = 13'd4096;

  // request kinds
  localparam logic [1:0] REQ_SEED     = 2'd0;
  localparam logic [1:0] REQ_CLEAR    = 2'd1;
  localparam logic [1:0] REQ_ADD      = 2'd2;
  localparam logic [1:0] REQ_RESAMPLE = 2'd3;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_ALPHA  = 3'd0;
  localparam logic [2:0] REG_BETA   = 3'd1;
  localparam logic [2:0] REG_TOPICS = 3'd2;
  localparam logic [2:0] REG_VOCAB  = 3'd3;
  localparam logic [2:0] REG_UPDATE = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] word;
    logic [5:0]  current_topic;
    logic [31:0] random_fraction;
  } req_t;

  typedef struct packed {
    logic [5:0] chosen_topic;
    logic       count_saturated;
  } rsp_t;

  // write strobes and clear request towards the count store
  typedef struct packed {
    logic we_word;
    logic we_glob;
    logic we_doc;
    logic doc_clear;
  } cnt_ctl_t;

  // width of (nwk << 16) + beta
  function automatic int a_bits(input int wcb);
    return (wcb + 16 > 32) ? wcb + 17 : 33;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lgts_count_store.sv =====
// ----------------------------------------------------------------------------
// lgts_count_store
// Word-topic, global-topic and document-topic count memories with registered read,
// with a clearing sweep after reset and a document sweep on request.
// ----------------------------------------------------------------------------
`default_nettype none

module lgts_count_store
  import lgts_pkg::*;
#(
  parameter int MAX_TOPICS      = MaxTopicsDefault,
  parameter int MAX_VOCABULARY  = MaxVocabularyDefault,
  parameter int WORD_COUNT_BITS = WordCountBitsDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cnt_ctl_t                   ctl,
  input  wire logic [$clog2(MAX_VOCABULARY)-1:0] word,
  input  wire logic [$clog2(MAX_TOPICS)-1:0]     topic,
  input  wire logic [WORD_COUNT_BITS-1:0] wdata_word,
  input  wire logic [31:0]                wdata_glob,
  input  wire logic [15:0]                wdata_doc,
  output logic      [WORD_COUNT_BITS-1:0] q_word,
  output logic      [31:0]                q_glob,
  output logic      [15:0]                q_doc,
  output logic                            sweeping
);

  localparam int TB    = $clog2(MAX_TOPICS);
  localparam int VB    = $clog2(MAX_VOCABULARY);
  localparam int AB    = TB + VB;
  localparam int DEPTH = MAX_VOCABULARY * (2 ** TB);

  logic [WORD_COUNT_BITS-1:0] word_mem [DEPTH];
  logic [31:0]                glob_mem [MAX_TOPICS];
  logic [15:0]                doc_mem  [MAX_TOPICS];

  logic          sweep_all;
  logic          sweep_doc;
  logic [AB-1:0] cnt;
  logic          cnt_topic_ok;
  logic [AB-1:0] waddr;
  logic [TB-1:0] taddr;

  assign sweeping     = sweep_all | sweep_doc;
  assign cnt_topic_ok = 32'(cnt) < MAX_TOPICS;
  assign waddr        = sweep_all ? cnt : {word, topic};
  assign taddr        = sweeping ? cnt[TB-1:0] : topic;

  // sweep control: full clear after reset, document clear on request
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_all <= 1'b1;
      sweep_doc <= 1'b0;
      cnt       <= '0;
    end else if (sweep_all) begin
      if (cnt == AB'(DEPTH - 1)) begin
        sweep_all <= 1'b0;
        cnt       <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end else if (sweep_doc) begin
      if (cnt[TB-1:0] == TB'(MAX_TOPICS - 1)) begin
        sweep_doc <= 1'b0;
        cnt       <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end else if (ctl.doc_clear) begin
      sweep_doc <= 1'b1;
      cnt       <= '0;
    end
  end

  // word-topic memory
  always_ff @(posedge clk) begin
    if (sweep_all || ctl.we_word) begin
      word_mem[waddr] <= sweep_all ? '0 : wdata_word;
    end
    q_word <= word_mem[{word, topic}];
  end

  // global-topic memory
  always_ff @(posedge clk) begin
    if ((sweep_all && cnt_topic_ok) || ctl.we_glob) begin
      glob_mem[taddr] <= sweep_all ? '0 : wdata_glob;
    end
    q_glob <= glob_mem[topic];
  end

  // document-topic memory
  always_ff @(posedge clk) begin
    if (((sweep_all || sweep_doc) && cnt_topic_ok) || ctl.we_doc) begin
      doc_mem[taddr] <= sweeping ? '0 : wdata_doc;
    end
    q_doc <= doc_mem[topic];
  end

`ifndef NO_ASSERTIONS
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !(ctl.we_word || ctl.we_glob || ctl.we_doc))
    else $error("count write while sweeping");
`endif

endmodule

`default_nettype wire

// ===== rtl/lgts_weight_unit.sv =====
// ----------------------------------------------------------------------------
// lgts_weight_unit
// floor(A*B/D) saturated to 48 bits: three-step multiply, then a restoring
// divide producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lgts_weight_unit
  import lgts_pkg::*;
#(
  parameter int WORD_COUNT_BITS = WordCountBitsDefault
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [a_bits(WORD_COUNT_BITS)-1:0] a,
  input  wire logic [32:0]                        b,
  input  wire logic [DivBits-1:0]                 d,
  output logic                                    busy,
  output logic                                    done,
  output logic      [WeightBits-1:0]              weight
);

  localparam int A_BITS = a_bits(WORD_COUNT_BITS);
  localparam int AH     = A_BITS - 32;
  localparam int P_BITS = A_BITS + 33;

  typedef enum logic [4:0] {
    W_IDLE = 5'b00001,
    W_M1   = 5'b00010,
    W_M2   = 5'b00100,
    W_CHK  = 5'b01000,
    W_DIV  = 5'b10000
  } wstate_t;

  wstate_t               state;
  logic [A_BITS-1:0]     a_r;
  logic [32:0]           b_r;
  logic [DivBits-1:0]    d_r;
  logic [P_BITS-1:0]     acc;
  logic [DivBits-1:0]    rem;
  logic [WeightBits-1:0] low_sh;
  logic [WeightBits-1:0] quo;
  logic [5:0]            cnt;

  logic [DivBits:0]      r2;
  logic                  ge;
  logic [P_BITS-1:0]     part_hi;
  logic                  over;

  assign busy = state != W_IDLE;

  always_comb begin
    r2      = {rem, low_sh[WeightBits-1]};
    ge      = r2 >= {1'b0, d_r};
    part_hi = P_BITS'({{(64-AH){1'b0}}, a_r[A_BITS-1:32]} * {32'd0, b_r[31:0]}) << 32;
    over    = (DivBits + 1)'(acc[P_BITS-1:WeightBits]) >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        W_IDLE: begin
          if (start) begin
            a_r   <= a;
            b_r   <= b;
            d_r   <= d;
            acc   <= P_BITS'({32'd0, a[31:0]} * {32'd0, b[31:0]});
            state <= W_M1;
          end
        end
        W_M1: begin
          acc   <= acc + part_hi;
          state <= W_M2;
        end
        W_M2: begin
          if (b_r[32]) begin
            acc <= acc + (P_BITS'(a_r) << 32);
          end
          state <= W_CHK;
        end
        W_CHK: begin
          if (over) begin
            weight <= WeightMax;
            done   <= 1'b1;
            state  <= W_IDLE;
          end else begin
            rem    <= DivBits'(acc[P_BITS-1:WeightBits]);
            low_sh <= acc[WeightBits-1:0];
            quo    <= '0;
            cnt    <= 6'(WeightBits - 1);
            state  <= W_DIV;
          end
        end
        W_DIV: begin
          // one restoring step per cycle
          rem    <= ge ? DivBits'(r2 - {1'b0, d_r}) : DivBits'(r2);
          low_sh <= low_sh << 1;
          quo    <= {quo[WeightBits-2:0], ge};
          if (cnt == '0) begin
            weight <= {quo[WeightBits-2:0], ge};
            done   <= 1'b1;
            state  <= W_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == W_IDLE)
    else $error("weight unit started while busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/lda_gibbs_topic_sampler_core.sv =====
// ----------------------------------------------------------------------------
// lda_gibbs_topic_sampler_core
// Collapsed Gibbs topic sampler for LDA with count memories and APB config.
// ----------------------------------------------------------------------------
// Items are taken on start while busy is low. Seed and add keep busy high
// while they read and write back their counts, a document clear keeps busy
// high while it sweeps the document counts, and a resample keeps busy high
// while, for each of the T topics in use, it reads the counts and runs a
// three-step multiply and a 48-step bit-serial divide in the weight unit,
// then the cumulative sums are scanned from their memory topic by topic and
// the counts are moved by read-modify-write. The result appears on rsp with
// done high for exactly one cycle and cannot be held off. After reset the
// count memories are cleared by a sweep over every word-topic entry, during
// which busy stays high; configuration writes are taken at any time but
// belong in idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module lda_gibbs_topic_sampler_core
  import lgts_pkg::*;
#(
  parameter int MAX_TOPICS      = MaxTopicsDefault,
  parameter int MAX_VOCABULARY  = MaxVocabularyDefault,
  parameter int WORD_COUNT_BITS = WordCountBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req,
  output logic             done,
  output rsp_t             rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int TB     = $clog2(MAX_TOPICS);
  localparam int VB     = $clog2(MAX_VOCABULARY);
  localparam int TK     = $clog2(MAX_TOPICS + 1);
  localparam int A_BITS = a_bits(WORD_COUNT_BITS);
  localparam logic [WORD_COUNT_BITS-1:0] WordMax = '1;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_W_RD   = 12'b000000000010,
    S_W_GO   = 12'b000000000100,
    S_W_WAIT = 12'b000000001000,
    S_TH0    = 12'b000000010000,
    S_TH1    = 12'b000000100000,
    S_SC_RD  = 12'b000001000000,
    S_SC_CMP = 12'b000010000000,
    S_DEC_RD = 12'b000100000000,
    S_DEC_WR = 12'b001000000000,
    S_INC_RD = 12'b010000000000,
    S_INC_WR = 12'b100000000000
  } state_t;

  // configuration registers
  logic [31:0] alpha_q16;
  logic [31:0] beta_q16;
  logic [6:0]  topics_in_use;
  logic [12:0] vocabulary_in_use;
  logic        model_update;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q16         <= AlphaReset;
      beta_q16          <= BetaReset;
      topics_in_use     <= TopicsReset;
      vocabulary_in_use <= VocabReset;
      model_update      <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ALPHA:  alpha_q16         <= pwdata;
        REG_BETA:   beta_q16          <= pwdata;
        REG_TOPICS: topics_in_use     <= pwdata[6:0];
        REG_VOCAB:  vocabulary_in_use <= pwdata[12:0];
        REG_UPDATE: model_update      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ALPHA:  prdata = alpha_q16;
      REG_BETA:   prdata = beta_q16;
      REG_TOPICS: prdata = 32'(topics_in_use);
      REG_VOCAB:  prdata = 32'(vocabulary_in_use);
      REG_UPDATE: prdata = 32'(model_update);
      default:    prdata = '0;
    endcase
  end

  // sequencer registers
  state_t                state;
  req_t                  req_r;
  logic                  wok_r;
  logic                  tok_r;
  logic [TK-1:0]         t_r;
  logic [TK-1:0]         k;
  logic [VbBits-1:0]     vb;
  logic [WeightBits-1:0] total;
  logic [WeightBits-1:0] choice;
  logic [TB-1:0]         chosen;
  logic                  sat_r;
  logic [63:0]           th_acc;
  logic [WeightBits-1:0] cum_q;
  logic [WeightBits-1:0] cum_mem [MAX_TOPICS];

  logic       sweeping;
  logic       accept;
  logic       is_res;
  cnt_ctl_t   ctl;

  assign busy   = (state != S_IDLE) | sweeping;
  assign accept = start & ~busy;
  assign is_res = req_r.req_type == REQ_RESAMPLE;

  // effective topic count
  logic [TK-1:0] t_eff;
  always_comb begin
    if (topics_in_use == '0) begin
      t_eff = TK'(1);
    end else if (32'(topics_in_use) > MAX_TOPICS) begin
      t_eff = TK'(MAX_TOPICS);
    end else begin
      t_eff = TK'(topics_in_use);
    end
  end

  // count store address and data
  logic [TB-1:0]              st_topic;
  logic [WORD_COUNT_BITS-1:0] q_word;
  logic [31:0]                q_glob;
  logic [15:0]                q_doc;
  logic [WORD_COUNT_BITS-1:0] wd_word;
  logic [31:0]                wd_glob;
  logic [15:0]                wd_doc;
  logic                       op_inc;
  logic                       sat_w;
  logic                       sat_g;
  logic                       sat_d;
  logic                       sat_step;

  always_comb begin
    if (state == S_DEC_RD || state == S_DEC_WR) begin
      st_topic = TB'(req_r.current_topic);
    end else if (state == S_INC_RD || state == S_INC_WR) begin
      st_topic = is_res ? chosen : TB'(req_r.current_topic);
    end else begin
      st_topic = TB'(k);
    end
  end

  // read-modify-write of one count in each table
  always_comb begin
    op_inc = state == S_INC_WR;
    if (op_inc) begin
      sat_w   = q_word == WordMax;
      sat_g   = q_glob == '1;
      sat_d   = q_doc == '1;
      wd_word = sat_w ? q_word : q_word + 1'b1;
      wd_glob = sat_g ? q_glob : q_glob + 1'b1;
      wd_doc  = sat_d ? q_doc : q_doc + 1'b1;
    end else begin
      sat_w   = q_word == '0;
      sat_g   = q_glob == '0;
      sat_d   = q_doc == '0;
      wd_word = sat_w ? q_word : q_word - 1'b1;
      wd_glob = sat_g ? q_glob : q_glob - 1'b1;
      wd_doc  = sat_d ? q_doc : q_doc - 1'b1;
    end

    ctl           = '0;
    ctl.doc_clear = accept && req.req_type == REQ_CLEAR;
    if (state == S_DEC_WR) begin
      ctl.we_word = model_update & wok_r & tok_r;
      ctl.we_glob = model_update & tok_r;
      ctl.we_doc  = tok_r;
    end else if (state == S_INC_WR) begin
      case (req_r.req_type)
        REQ_SEED: begin
          ctl.we_word = wok_r & tok_r;
          ctl.we_glob = tok_r;
        end
        REQ_ADD: ctl.we_doc = tok_r;
        REQ_RESAMPLE: begin
          ctl.we_word = model_update & wok_r;
          ctl.we_glob = model_update;
          ctl.we_doc  = 1'b1;
        end
        default: ;
      endcase
    end
    sat_step = (ctl.we_word & sat_w) | (ctl.we_glob & sat_g) | (ctl.we_doc & sat_d);
  end

  lgts_count_store #(
    .MAX_TOPICS      (MAX_TOPICS),
    .MAX_VOCABULARY  (MAX_VOCABULARY),
    .WORD_COUNT_BITS (WORD_COUNT_BITS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .word       (VB'(req_r.word)),
    .topic      (st_topic),
    .wdata_word (wd_word),
    .wdata_glob (wd_glob),
    .wdata_doc  (wd_doc),
    .q_word     (q_word),
    .q_glob     (q_glob),
    .q_doc      (q_doc),
    .sweeping   (sweeping)
  );

  // weight operands, own counts taken out
  logic                       own;
  logic [WORD_COUNT_BITS-1:0] nwk;
  logic [31:0]                nk;
  logic [15:0]                ndk;
  logic [A_BITS-1:0]          a_in;
  logic [32:0]                b_in;
  logic [DivBits-1:0]         d_sum;
  logic [DivBits-1:0]         d_in;

  always_comb begin
    own = model_update && (32'(k) == 32'(req_r.current_topic));
    nwk = wok_r ? q_word : '0;
    nk  = q_glob;
    ndk = q_doc;
    if (own && nwk != '0) nwk = nwk - 1'b1;
    if (own && nk != '0)  nk  = nk - 1'b1;
    if (own && ndk != '0) ndk = ndk - 1'b1;
    a_in  = (A_BITS'(nwk) << 16) + A_BITS'(beta_q16);
    b_in  = {1'b0, ndk, 16'b0} + 33'(alpha_q16);
    d_sum = (DivBits'(nk) << 16) + DivBits'(vb);
    d_in  = (d_sum == '0) ? DivBits'(1) : d_sum;
  end

  logic                  wu_busy;
  logic                  wu_done;
  logic [WeightBits-1:0] wu_weight;

  lgts_weight_unit #(
    .WORD_COUNT_BITS (WORD_COUNT_BITS)
  ) u_weight (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_W_GO),
    .a      (a_in),
    .b      (b_in),
    .d      (d_in),
    .busy   (wu_busy),
    .done   (wu_done),
    .weight (wu_weight)
  );

  // saturating running total
  logic [WeightBits:0]   sum_w;
  logic [WeightBits-1:0] total_next;
  logic [79:0]           th_sum;

  always_comb begin
    sum_w      = {1'b0, total} + {1'b0, wu_weight};
    total_next = sum_w[WeightBits] ? WeightMax : sum_w[WeightBits-1:0];
    th_sum     = 80'(th_acc) +
                 (80'({16'd0, total[47:32]} * {16'd0, req_r.random_fraction}) << 32);
  end

  // cumulative weight memory
  always_ff @(posedge clk) begin
    if (state == S_W_WAIT && wu_done) begin
      cum_mem[TB'(k)] <= total_next;
    end
    cum_q <= cum_mem[TB'(k)];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_r <= req;
            wok_r <= 32'(req.word) < MAX_VOCABULARY;
            tok_r <= 32'(req.current_topic) < MAX_TOPICS;
            t_r   <= t_eff;
            vb    <= VbBits'(vocabulary_in_use) * VbBits'(beta_q16);
            sat_r <= 1'b0;
            k     <= '0;
            total <= '0;
            case (req.req_type)
              REQ_SEED, REQ_ADD: state <= S_INC_RD;
              REQ_RESAMPLE:      state <= S_W_RD;
              default:           state <= S_IDLE;
            endcase
          end
        end
        S_W_RD: state <= S_W_GO;
        S_W_GO: state <= S_W_WAIT;
        S_W_WAIT: begin
          if (wu_done) begin
            total <= total_next;
            if (k == t_r - 1'b1) begin
              state <= S_TH0;
            end else begin
              k     <= k + 1'b1;
              state <= S_W_RD;
            end
          end
        end
        S_TH0: begin
          th_acc <= total[31:0] * req_r.random_fraction;
          state  <= S_TH1;
        end
        S_TH1: begin
          choice <= th_sum[79:32];
          k      <= '0;
          state  <= S_SC_RD;
        end
        S_SC_RD: state <= S_SC_CMP;
        S_SC_CMP: begin
          // first topic whose running sum reaches the threshold, else the last topic in use
          if (cum_q >= choice || k == t_r - 1'b1) begin
            chosen <= TB'(k);
            state  <= S_DEC_RD;
          end else begin
            k     <= k + 1'b1;
            state <= S_SC_RD;
          end
        end
        S_DEC_RD: state <= S_DEC_WR;
        S_DEC_WR: begin
          sat_r <= sat_r | sat_step;
          state <= S_INC_RD;
        end
        S_INC_RD: state <= S_INC_WR;
        S_INC_WR: begin
          if (is_res) begin
            done                <= 1'b1;
            rsp.chosen_topic    <= 6'(chosen);
            rsp.count_saturated <= sat_r | sat_step;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_move: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_INC_WR))
    else $error("result without count move");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("not busy after accepted word");
  a_topic_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> 32'(rsp.chosen_topic) < 32'(t_r))
    else $error("chosen topic out of range");
  a_unit_idle_on_go: assert property (@(posedge clk) disable iff (rst)
    state == S_W_GO |-> !wu_busy)
    else $error("weight unit busy at launch");
`endif

endmodule

`default_nettype wire
